// ----- rtl/lpht_pkg.sv -----
// Shared constants, codes and types of the linear probing hash table.
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 32;
    localparam int KEY_W           = 160;
    localparam int VALUE_W         = 64;
    localparam int KEY_BYTES       = 20;
    localparam int HASH_W          = 32;
    localparam int SLOT_W          = 5;
    localparam int IN_DATA_W       = 224;
    localparam int OUT_DATA_W      = 72;

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        H_IDLE,
        H_ROUND,
        H_FIN0,
        H_FIN1,
        H_FIN2,
        H_MOD,
        H_RED
    } hash_state_t;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_HASH,
        T_READ,
        T_CHECK
    } top_state_t;

    typedef struct packed {
        logic       state_we;
        logic       data_we;
        logic [1:0] state;
    } store_wr_t;

endpackage

// ----- rtl/lpht_hash.sv -----
// Iterative one-at-a-time hash unit; the home slot is the hash modulo the table size, from low bits or a reciprocal.
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = (TABLE_SLOTS == (1 << IDX_W));
    localparam logic [HASH_W-1:0] SLOTS_H = HASH_W'(TABLE_SLOTS);
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_SLOTS);
    localparam logic [4:0] LAST_ROUND = 5'(KEY_BYTES - 1);

    hash_state_t        state_reg;
    hash_state_t        state_next;
    logic [4:0]         cnt_reg;
    logic [4:0]         cnt_next;
    logic               done_reg;
    logic               done_next;
    logic [HASH_W-1:0]  h_reg;
    logic [HASH_W-1:0]  h_next;
    logic [HASH_W-1:0]  q_reg;
    logic [HASH_W-1:0]  q_next;
    logic [IDX_W-1:0]   rem_reg;
    logic [IDX_W-1:0]   rem_next;

    logic [7:0]          key_byte;
    logic [HASH_W-1:0]   round_a;
    logic [HASH_W-1:0]   round_b;
    logic [HASH_W-1:0]   round_c;
    logic [HASH_W-1:0]   fin0;
    logic [HASH_W-1:0]   fin1;
    logic [HASH_W-1:0]   fin2;
    logic [2*HASH_W-1:0] prod;
    logic [HASH_W-1:0]   q_times_n;
    logic [HASH_W-1:0]   diff;
    logic [HASH_W-1:0]   diff_sub;
    logic [IDX_W-1:0]    rem_new;

    assign key_byte = key[{cnt_reg, 3'b000} +: 8];
    assign round_a  = h_reg + {24'd0, key_byte};
    assign round_b  = round_a + (round_a << 10);
    assign round_c  = round_b ^ (round_b >> 6);
    assign fin0     = h_reg + (h_reg << 3);
    assign fin1     = h_reg ^ (h_reg >> 11);
    assign fin2     = h_reg + (h_reg << 15);

    // The estimated quotient is at most one below the true one, so one subtraction finishes.
    assign prod      = {{HASH_W{1'b0}}, h_reg} * {{HASH_W{1'b0}}, RECIP};
    assign q_times_n = q_reg * SLOTS_H;
    assign diff      = h_reg - q_times_n;
    assign diff_sub  = diff - SLOTS_H;
    assign rem_new   = (diff >= SLOTS_H) ? diff_sub[IDX_W-1:0] : diff[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    state_next = H_ROUND;
                end
            end
            H_ROUND:
            begin
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = H_FIN0;
                end
            end
            H_FIN0:
            begin
                state_next = H_FIN1;
            end
            H_FIN1:
            begin
                state_next = H_FIN2;
            end
            H_FIN2:
            begin
                state_next = IS_POW2 ? H_IDLE : H_MOD;
            end
            H_MOD:
            begin
                state_next = H_RED;
            end
            H_RED:
            begin
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_comb
    begin
        h_next    = h_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next   = '0;
                    cnt_next = '0;
                end
            end
            H_ROUND:
            begin
                h_next   = round_c;
                cnt_next = (cnt_reg == LAST_ROUND) ? 5'd0 : cnt_reg + 5'd1;
            end
            H_FIN0:
            begin
                h_next = fin0;
            end
            H_FIN1:
            begin
                h_next = fin1;
            end
            H_FIN2:
            begin
                h_next   = fin2;
                cnt_next = '0;
                rem_next = '0;
                if (IS_POW2)
                begin
                    rem_next  = fin2[IDX_W-1:0];
                    done_next = 1'b1;
                end
            end
            H_MOD:
            begin
                q_next = prod[2*HASH_W-1:HASH_W];
            end
            H_RED:
            begin
                rem_next  = rem_new;
                done_next = 1'b1;
            end
            default:
            begin
                h_next = h_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

// ----- rtl/lpht_store.sv -----
// Slot state, key and value memories with one shared address and registered reads.
module lpht_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                           clk,
    input  store_wr_t                      wr,
    input  logic [$clog2(TABLE_SLOTS)-1:0] addr,
    input  logic [KEY_W-1:0]               wr_key,
    input  logic [VALUE_W-1:0]             wr_value,
    output logic [1:0]                     rd_state,
    output logic [KEY_W-1:0]               rd_key,
    output logic [VALUE_W-1:0]             rd_value
);

    logic [1:0]               state_mem [TABLE_SLOTS];
    logic [KEY_W+VALUE_W-1:0] data_mem [TABLE_SLOTS];
    logic [1:0]               rd_state_reg;
    logic [KEY_W+VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.state_we)
        begin
            state_mem[addr] <= wr.state;
        end
        rd_state_reg <= state_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            data_mem[addr] <= {wr_value, wr_key};
        end
        rd_data_reg <= data_mem[addr];
    end

    assign rd_state = rd_state_reg;
    assign rd_key   = rd_data_reg[KEY_W-1:0];
    assign rd_value = rd_data_reg[KEY_W+VALUE_W-1:KEY_W];

endmodule

// ----- rtl/linear_probe_hash_table_top.sv -----
// Top level of the linear probing hash table: request sequencer and result register.
//
//  Channel | Direction | tdata (low bit up)                   | tuser
//  s_*     | in        | key_low, key_mid, key_high, value_in | mode
//  m_*     | out       | value_out, slot_index, zero fill     | status
//
// A transaction passes through the shared hash unit in 20 rounds and 3 finishing steps, plus
// 2 remainder steps when TABLE_SLOTS is not a power of two. Each probe is a read state and a
// check state, set by the registered read of the slot memories; the result is registered at
// the end of the last probe, and s_tready returns as it is registered.
// After reset a clearing pass empties every slot state; s_tready is low meanwhile.
// A finished result waits in the output register while the next transaction is accepted;
// the following result holds the sequencer in its check cycle until m_tready frees it.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key_low, key_mid, key_high, value_in
    input  logic [1:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // value_out, slot_index, zero fill
    output logic [1:0]            m_tuser    // status
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    top_state_t          state_reg;
    top_state_t          state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [IDX_W-1:0]    probe_reg;
    logic [IDX_W-1:0]    probe_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [1:0]          mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic                accept;
    logic                hash_done;
    logic [IDX_W-1:0]    home;
    store_wr_t           store_wr;
    store_wr_t           wr_dec;
    logic [1:0]          rd_state;
    logic [KEY_W-1:0]    rd_key;
    logic [VALUE_W-1:0]  rd_value;
    logic                key_hit;
    logic                last_probe;
    logic                out_free;
    logic                finish;
    logic                out_load;
    logic [1:0]          res_status;
    logic [VALUE_W-1:0]  res_value;
    logic [SLOT_W-1:0]   res_slot;
    logic [IDX_W-1:0]    idx_wrap;

    assign s_tready   = (state_reg == T_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign key_hit    = (rd_state == SLOT_USED) && (rd_key == key_reg);
    assign last_probe = (probe_reg == LAST_IDX);
    assign out_free   = !out_valid_reg || m_tready;
    assign idx_wrap   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
    assign out_load   = (state_reg == T_CHECK) && finish && out_free;

    lpht_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key_reg),
        .done  (hash_done),
        .home  (home)
    );

    lpht_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .clk      (clk),
        .wr       (store_wr),
        .addr     (idx_reg),
        .wr_key   (key_reg),
        .wr_value (value_reg),
        .rd_state (rd_state),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    always_comb
    begin
        finish     = 1'b0;
        res_status = ST_MISS;
        res_value  = '0;
        wr_dec     = '{state_we: 1'b0, data_we: 1'b0, state: SLOT_EMPTY};
        priority if (mode_reg == MODE_SEARCH || mode_reg == MODE_DELETE)
        begin
            if (rd_state == SLOT_EMPTY)
            begin
                finish = 1'b1;
            end
            else if (key_hit)
            begin
                finish     = 1'b1;
                res_status = ST_OK;
                res_value  = rd_value;
                if (mode_reg == MODE_DELETE)
                begin
                    wr_dec = '{state_we: 1'b1, data_we: 1'b0, state: SLOT_DELETED};
                end
            end
            else if (last_probe)
            begin
                finish = 1'b1;
            end
        end
        else if (mode_reg == MODE_INSERT)
        begin
            if (rd_state != SLOT_USED)
            begin
                finish     = 1'b1;
                res_status = ST_OK;
                wr_dec     = '{state_we: 1'b1, data_we: 1'b1, state: SLOT_USED};
            end
            else if (last_probe)
            begin
                finish     = 1'b1;
                res_status = ST_FULL;
            end
        end
        else
        begin
            finish = 1'b1;
        end
        res_slot = (res_status == ST_OK) ? SLOT_W'(idx_reg) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = T_HASH;
                end
            end
            T_HASH:
            begin
                if (hash_done)
                begin
                    state_next = T_READ;
                end
            end
            T_READ:
            begin
                state_next = T_CHECK;
            end
            T_CHECK:
            begin
                if (!finish)
                begin
                    state_next = T_READ;
                end
                else if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        out_valid_next = out_valid_reg && !m_tready;
        store_wr       = '{state_we: 1'b0, data_we: 1'b0, state: SLOT_EMPTY};
        unique case (state_reg)
            T_CLEAR:
            begin
                store_wr = '{state_we: 1'b1, data_we: 1'b0, state: SLOT_EMPTY};
                idx_next = idx_wrap;
            end
            T_IDLE:
            begin
                idx_next = idx_reg;
            end
            T_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = home;
                    probe_next = '0;
                end
            end
            T_READ:
            begin
                idx_next = idx_reg;
            end
            T_CHECK:
            begin
                if (!finish)
                begin
                    idx_next   = idx_wrap;
                    probe_next = probe_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    store_wr       = wr_dec;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_CLEAR;
            idx_reg       <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_slot_reg   <= res_slot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(OUT_DATA_W - VALUE_W - SLOT_W)'(0), out_slot_reg, out_value_reg};

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("Probe index left the table.");

    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == T_HASH)
        else $error("Hash unit finished outside the hash phase.");

    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && state_reg == T_IDLE)
        else $error("Loaded result was not presented.");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.state_we |-> state_reg == T_CLEAR || state_reg == T_CHECK)
        else $error("Slot state written outside the clear or check phase.");
`endif

endmodule

// ----- bench/lpht_reply_checker.sv -----
// Passive checker for the hash table: predicts each reply from the accepted requests and compares.
`timescale 1ns / 1ps

module lpht_reply_checker
    import lpht_pkg::*;
#(
    parameter int SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key_low, key_mid, key_high, value_in
    input  logic [1:0]            s_tuser,   // mode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // value_out, slot_index, zero fill
    input  logic [1:0]            m_tuser,   // status
    output int                    fail_count,
    output int                    pending,
    output int                    hit_count,
    output int                    miss_count,
    output int                    full_count
);

    typedef struct {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  slot;
    } table_reply_t;

    logic [1:0]         slot_mark  [SLOTS];
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [VALUE_W-1:0] slot_value [SLOTS];

    table_reply_t replies_due[$];
    table_reply_t want;
    table_reply_t got;
    int           reply_number;

    function automatic logic [HASH_W-1:0] key_hash(logic [KEY_W-1:0] key);
        logic [HASH_W-1:0] h;
        int                n;
        h = '0;
        for (n = 0; n < KEY_BYTES; n++)
        begin
            h = h + key[8*n +: 8];
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic table_reply_t predict_reply(logic [1:0] mode, logic [KEY_W-1:0] key,
                                                   logic [VALUE_W-1:0] val);
        table_reply_t r;
        int           idx;
        int           n;
        bit           done;
        r.status = ST_MISS;
        r.value  = '0;
        r.slot   = '0;
        idx      = key_hash(key) % SLOTS;
        done     = 1'b0;
        if (mode == MODE_SEARCH || mode == MODE_DELETE)
        begin
            for (n = 0; n < SLOTS && !done; n++)
            begin
                if (slot_mark[idx] == SLOT_EMPTY)
                    done = 1'b1;
                else if (slot_mark[idx] == SLOT_USED && slot_key[idx] == key)
                begin
                    done     = 1'b1;
                    r.status = ST_OK;
                    r.value  = slot_value[idx];
                    r.slot   = SLOT_W'(idx);
                    if (mode == MODE_DELETE)
                        slot_mark[idx] = SLOT_DELETED;
                end
                else
                    idx = (idx + 1) % SLOTS;
            end
        end
        else if (mode == MODE_INSERT)
        begin
            r.status = ST_FULL;
            for (n = 0; n < SLOTS && !done; n++)
            begin
                if (slot_mark[idx] != SLOT_USED)
                begin
                    done            = 1'b1;
                    slot_mark[idx]  = SLOT_USED;
                    slot_key[idx]   = key;
                    slot_value[idx] = val;
                    r.status        = ST_OK;
                    r.slot          = SLOT_W'(idx);
                end
                else
                    idx = (idx + 1) % SLOTS;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] seen, logic [VALUE_W-1:0] due);
        $display("reply %0d: %s, got %h, expected %h", reply_number, what, seen, due);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_mark[i] = SLOT_EMPTY;
            replies_due.delete();
            fail_count   = 0;
            hit_count    = 0;
            miss_count   = 0;
            full_count   = 0;
            reply_number = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.value  = m_tdata[VALUE_W-1:0];
                got.slot   = m_tdata[VALUE_W +: SLOT_W];
                case (got.status)
                    ST_OK:   hit_count++;
                    ST_MISS: miss_count++;
                    default: full_count++;
                endcase
                if (replies_due.size() == 0)
                    report_mismatch("reply with no request outstanding", got.value, '0);
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.value !== want.value)
                        report_mismatch("value_out", got.value, want.value);
                    if (got.slot !== want.slot)
                        report_mismatch("slot_index", got.slot, want.slot);
                end
                reply_number++;
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(predict_reply(s_tuser, s_tdata[KEY_W-1:0],
                                                    s_tdata[KEY_W +: VALUE_W]));
        end
        pending = replies_due.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the hash table: clock, reset, request stimulus, reply stalls and verdict.
`timescale 1ns / 1ps

module tb_top
    import lpht_pkg::*;
;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         TAIL_CYCLES    = 200;
    localparam int         SEGMENT_ITEMS  = 105;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    int fail_count;
    int pending;
    int hit_count;
    int miss_count;
    int full_count;

    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    int search_count;
    int insert_count;
    int delete_count;
    int unused_count;

    logic [KEY_W-1:0] known_keys[$];

    int idle_plan  [4] = '{0, 63, 0, 29};
    int stall_plan [4] = '{0, 0, 63, 29};

    linear_probe_hash_table_top #(
        .TABLE_SLOTS (TABLE_SLOTS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lpht_reply_checker #(
        .SLOTS (TABLE_SLOTS_DEF)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .hit_count  (hit_count),
        .miss_count (miss_count),
        .full_count (full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] fresh_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(logic [1:0] mode, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, key};
        s_tuser  <= mode;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        case (mode)
            MODE_SEARCH: search_count++;
            MODE_INSERT: insert_count++;
            MODE_DELETE: delete_count++;
            default:     unused_count++;
        endcase
    endtask

    task automatic random_request(int insert_pct, int delete_pct);
        int                 r;
        logic [1:0]         mode;
        logic [KEY_W-1:0]   key;
        r = $urandom_range(99);
        if (r < insert_pct)
            mode = MODE_INSERT;
        else if (r < insert_pct + delete_pct)
            mode = MODE_DELETE;
        else if (r < 97)
            mode = MODE_SEARCH;
        else
            mode = MODE_UNUSED;
        if (known_keys.size() != 0 &&
            $urandom_range(99) < ((mode == MODE_INSERT) ? 15 : 75))
            key = known_keys[$urandom_range(known_keys.size() - 1)];
        else
            key = fresh_key();
        if (mode == MODE_INSERT)
        begin
            known_keys.push_back(key);
            if (known_keys.size() > 48)
                known_keys.delete(0);
        end
        send_request(mode, key, fresh_value());
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        s_tvalid           <= 1'b0;
        s_tdata            <= '0;
        s_tuser            <= MODE_SEARCH;
        rst_n              <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        search_count       = 0;
        insert_count       = 0;
        delete_count       = 0;
        unused_count       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, duplicates, tombstones, near-miss keys and the unused mode.
        send_request(MODE_SEARCH, '0, '1);
        send_request(MODE_INSERT, '0, '1);
        send_request(MODE_INSERT, '1, '0);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_SEARCH, '1, '1);
        send_request(MODE_INSERT, '0, 64'h5);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_DELETE, '0, '0);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_DELETE, '0, '0);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_DELETE, '0, '0);
        send_request(MODE_INSERT, '0, {2{32'hA5A5_5A5A}});
        send_request(MODE_UNUSED, '1, '1);
        send_request(MODE_SEARCH, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        send_request(MODE_SEARCH, {8'h01, {(KEY_W-8){1'b0}}}, '0);
        send_request(MODE_INSERT, {5{32'h5555_5555}}, {2{32'hAAAA_AAAA}});
        send_request(MODE_SEARCH, {5{32'h5555_5555}}, '0);
        send_request(MODE_DELETE, {5{32'h5555_5555}}, '1);
        send_request(MODE_DELETE, '1, '0);
        send_request(MODE_SEARCH, '1, '0);
        send_request(MODE_UNUSED, {5{32'hAAAA_AAAA}}, '1);
        drain_replies();

        // Each idle/stall phase fills the table past full, then drains it with deletes.
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_plan[p];
            receiver_stall_pct = stall_plan[p];
            repeat (SEGMENT_ITEMS) random_request(80, 5);
            drain_replies();
            repeat (SEGMENT_ITEMS) random_request(20, 55);
            drain_replies();
        end

        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d searches, %0d inserts, %0d deletes, %0d unused mode.",
                 search_count + insert_count + delete_count + unused_count,
                 search_count, insert_count, delete_count, unused_count);
        $display("Replies: %0d done or found, %0d not found, %0d table full, over 4 idle phases.",
                 hit_count, miss_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- linear_probe_hash_table_top.f -----
rtl/lpht_pkg.sv
rtl/lpht_hash.sv
rtl/lpht_store.sv
rtl/linear_probe_hash_table_top.sv
bench/lpht_reply_checker.sv
bench/tb_top.sv
